/* src/ckc_pkg.sv */
// Shared constants, types and codes for the canonical k-mer count table.
// No dependencies; every other file in src except ckc_ram refers to it by scoped names.
package ckc_pkg;

	localparam int TABLE_SIZE     = 4096;
	localparam int OVERFLOW_SLOTS = 256;
	localparam int TOTAL_SLOTS    = TABLE_SIZE + OVERFLOW_SLOTS;
	localparam int HASH_W         = $clog2(TABLE_SIZE);
	localparam int ADDR_W         = $clog2(TOTAL_SLOTS);

	localparam int CHAR_W  = 8;
	localparam int KLEN_W  = 5;
	localparam int KMER_W  = 62;
	localparam int COUNT_W = 8;
	localparam int SLOT_W  = 13;
	localparam int ENTRY_W = KMER_W + COUNT_W;

	localparam int HASH_BYTES = 8;
	localparam int HASH_CNT_W = $clog2(HASH_BYTES);
	localparam int DJB_SEED   = 5381;

	localparam logic [KLEN_W-1:0]  KLEN_RESET = KLEN_W'(30);
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [CHAR_W-1:0]  CHAR_N     = 8'd78;
	localparam logic [CHAR_W-1:0]  CHAR_NL    = 8'd10;
	localparam logic [1:0]         COMP_FLIP  = 2'b10;

	// Command to the rolling k-mer registers.
	typedef struct packed {
		logic       clear;
		logic       shift;
		logic [1:0] code;
	} roll_ctl_t;

endpackage

/* src/ckc_if.sv */
// Valid/ready channel interfaces: sequence characters in, count results out.
// Depends on ckc_pkg for field widths.
interface ckc_char_if;
	logic                        valid;
	logic                        ready;
	logic [ckc_pkg::CHAR_W-1:0]  base_char;
	logic                        restart;

	modport source(output valid, output base_char, output restart, input ready);
	modport sink(input valid, input base_char, input restart, output ready);
endinterface

interface ckc_count_if;
	logic                        valid;
	logic                        ready;
	logic [ckc_pkg::KMER_W-1:0]  canonical_kmer;
	logic [ckc_pkg::SLOT_W-1:0]  slot;
	logic [ckc_pkg::COUNT_W-1:0] occurrences;
	logic                        newly_inserted;
	logic                        table_full;

	modport source(output valid, output canonical_kmer, output slot, output occurrences,
		output newly_inserted, output table_full, input ready);
	modport sink(input valid, input canonical_kmer, input slot, input occurrences,
		input newly_inserted, input table_full, output ready);
endinterface

/* src/ckc_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module ckc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* src/ckc_roll.sv */
// Rolling forward and reverse-complement k-mer registers with base counter.
// Depends on ckc_pkg (widths, roll_ctl_t).
module ckc_roll (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ckc_pkg::KLEN_W-1:0] kmer_length,
	input  ckc_pkg::roll_ctl_t         ctl,
	output logic [ckc_pkg::KMER_W-1:0] canon,
	output logic                       kmer_ready
);
	logic [ckc_pkg::KMER_W-1:0] fwd_q, rev_q, kmask, ins, fwd_d, rev_d;
	logic [ckc_pkg::KLEN_W-1:0] seen_q, k_eff;
	logic [5:0]                 klen2;
	logic [1:0]                 comp;

	// Zero length acts as one base.
	assign k_eff = (kmer_length == '0) ? ckc_pkg::KLEN_W'(1) : kmer_length;
	assign klen2 = {k_eff, 1'b0};
	assign kmask = {ckc_pkg::KMER_W{1'b1}} >> (6'(ckc_pkg::KMER_W) - klen2);
	assign comp  = ctl.code ^ ckc_pkg::COMP_FLIP;
	assign ins   = {{(ckc_pkg::KMER_W-2){1'b0}}, comp} << (klen2 - 6'd2);
	assign fwd_d = {fwd_q[ckc_pkg::KMER_W-3:0], ctl.code} & kmask;
	assign rev_d = ((rev_q >> 2) | ins) & kmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			seen_q <= '0;
		end else if (ctl.clear) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			seen_q <= '0;
		end else if (ctl.shift) begin
			fwd_q <= fwd_d;
			rev_q <= rev_d;
			if (seen_q < k_eff) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	assign canon      = (fwd_q < rev_q) ? fwd_q : rev_q;
	assign kmer_ready = (seen_q >= k_eff);
endmodule

/* src/ckc_hash.sv */
// Iterative DJB hash: one key byte per cycle, kept to the table index width.
// Depends on ckc_pkg (widths, seed, byte count).
module ckc_hash (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ckc_pkg::KMER_W-1:0] key,
	output logic                       done,
	output logic [ckc_pkg::HASH_W-1:0] hash
);
	localparam int SH_W = 8 * ckc_pkg::HASH_BYTES;
	localparam logic [ckc_pkg::HASH_W-1:0] SEED = ckc_pkg::HASH_W'(ckc_pkg::DJB_SEED);

	logic [SH_W-1:0]                bytes_q;
	logic [ckc_pkg::HASH_W-1:0]     h_q;
	logic [ckc_pkg::HASH_CNT_W-1:0] cnt_q;
	logic                           busy_q, done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			bytes_q <= SH_W'(key);
			h_q     <= SEED;
		end else if (busy_q) begin
			// h*33 + byte; only the low index bits are ever used
			h_q     <= (h_q << 5) + h_q + ckc_pkg::HASH_W'(bytes_q[7:0]);
			bytes_q <= bytes_q >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ckc_pkg::HASH_CNT_W'(ckc_pkg::HASH_BYTES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign hash = h_q;
endmodule

/* src/canonical_kmer_count_table_core.sv */
// Top level of the canonical k-mer count table: sequencer, probe logic, result register.
// Depends on ckc_pkg, ckc_if, ckc_ram, ckc_roll and ckc_hash.
//
// Usage: sequence characters enter on chars (valid/ready); one transaction per
// character. restart or 'N' clears the rolling k-mer, newline is skipped, any
// other character shifts in a base. Once kmer_length bases are held and the
// canonical k-mer is nonzero, it is hashed, the table is probed linearly and
// one result transaction leaves on counts. The user must write kmer_length through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce it.
// Flow: chars.ready is high only in the idle state. A skipped or clearing
// character leaves the block idle; a rolled one passes through the canon state.
// A counted k-mer then runs the byte-serial hash of the key, reads and checks
// one slot per probe, writes back on a hit (or goes straight to output when
// probing runs off the table end), and returns to idle from the output state,
// where the next character can be taken.
// Reset: the rolling state clears at once and kmer_length returns to 30; then a
// clearing pass writes all 4352 table slots, one per cycle, with chars.ready low throughout.
// Stall: a finished result waits in the output register; the block keeps taking
// characters, and only holds in its output state if a second result is ready
// before the first is taken.
module canonical_kmer_count_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [ckc_pkg::KLEN_W-1:0]  cfg_wr_data,
	ckc_char_if.sink                    chars,
	ckc_count_if.source                 counts
);
	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_CANON = 8'b0000_0100,
		ST_HASH  = 8'b0000_1000,
		ST_READ  = 8'b0001_0000,
		ST_CHECK = 8'b0010_0000,
		ST_WRITE = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	localparam logic [ckc_pkg::ADDR_W:0] TOTAL_EXT = (ckc_pkg::ADDR_W+1)'(ckc_pkg::TOTAL_SLOTS);
	localparam logic [ckc_pkg::ADDR_W-1:0] LAST_SLOT =
		ckc_pkg::ADDR_W'(ckc_pkg::TOTAL_SLOTS - 1);

	state_t                          state_q;
	logic [ckc_pkg::KLEN_W-1:0]      klen_q;
	logic [ckc_pkg::ADDR_W-1:0]      clr_q, idx_q;
	logic [ckc_pkg::KMER_W-1:0]      canon_q;
	logic [ckc_pkg::COUNT_W-1:0]     res_cnt_q;
	logic                            res_new_q, res_full_q;

	logic                            out_valid_q;
	logic [ckc_pkg::KMER_W-1:0]      out_kmer_q;
	logic [ckc_pkg::SLOT_W-1:0]      out_slot_q;
	logic [ckc_pkg::COUNT_W-1:0]     out_cnt_q;
	logic                            out_new_q, out_full_q;

	ckc_pkg::roll_ctl_t              roll_ctl;
	logic [ckc_pkg::KMER_W-1:0]      roll_canon;
	logic                            roll_ready;
	logic                            hash_start, hash_done;
	logic [ckc_pkg::HASH_W-1:0]      hash_val;

	logic                            ram_we;
	logic [ckc_pkg::ADDR_W-1:0]      ram_waddr;
	logic [ckc_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;
	logic [ckc_pkg::KMER_W-1:0]      rd_key;
	logic [ckc_pkg::COUNT_W-1:0]     rd_cnt;
	logic [ckc_pkg::ADDR_W:0]        idx_inc;
	logic                            char_take, is_clear, is_skip, hit, load_out;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= ckc_pkg::KLEN_RESET;
		end else if (cfg_wr_en) begin
			klen_q <= cfg_wr_data;
		end
	end

	// Decode the incoming character into a rolling-register command.
	assign chars.ready = (state_q == ST_IDLE);
	assign char_take   = chars.valid && chars.ready;
	assign is_clear    = chars.restart || (chars.base_char == ckc_pkg::CHAR_N);
	assign is_skip     = (chars.base_char == ckc_pkg::CHAR_NL);

	always_comb begin
		roll_ctl.clear = char_take && is_clear;
		roll_ctl.shift = char_take && !is_clear && !is_skip;
		roll_ctl.code  = chars.base_char[2:1];
	end

	ckc_roll u_roll (
		.clk         (clk),
		.arst_n      (arst_n),
		.kmer_length (klen_q),
		.ctl         (roll_ctl),
		.canon       (roll_canon),
		.kmer_ready  (roll_ready)
	);

	// Start hashing once the fresh canonical k-mer is known to count.
	assign hash_start = (state_q == ST_CANON) && roll_ready && (roll_canon != '0);

	ckc_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (roll_canon),
		.done   (hash_done),
		.hash   (hash_val)
	);

	// Table: key in the upper bits, saturating count in the lower bits.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {canon_q, res_cnt_q};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_WRITE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ckc_ram #(
		.WIDTH (ckc_pkg::ENTRY_W),
		.DEPTH (ckc_pkg::TOTAL_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_key   = ram_rdata[ckc_pkg::ENTRY_W-1 -: ckc_pkg::KMER_W];
	assign rd_cnt   = ram_rdata[ckc_pkg::COUNT_W-1:0];
	assign hit      = (rd_key == '0) || (rd_key == canon_q);
	assign idx_inc  = {1'b0, idx_q} + 1'b1;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || counts.ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (roll_ctl.shift) begin
						state_q <= ST_CANON;
					end
				end
				ST_CANON: begin
					state_q <= hash_start ? ST_HASH : ST_IDLE;
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (hit) begin
						state_q <= ST_WRITE;
					end else if (idx_inc >= TOTAL_EXT) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_WRITE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Probe datapath: key, slot and updated count of the current k-mer.
	always_ff @(posedge clk) begin
		if (hash_start) begin
			canon_q <= roll_canon;
		end
		if ((state_q == ST_HASH) && hash_done) begin
			idx_q <= ckc_pkg::ADDR_W'(hash_val);
		end else if ((state_q == ST_CHECK) && !hit && (idx_inc < TOTAL_EXT)) begin
			idx_q <= idx_inc[ckc_pkg::ADDR_W-1:0];
		end
		if (state_q == ST_CHECK) begin
			if (hit) begin
				res_new_q  <= (rd_key == '0);
				res_full_q <= 1'b0;
				res_cnt_q  <= (rd_cnt == ckc_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
			end else begin
				// Ran past the last slot: report full, count nothing.
				res_new_q  <= 1'b0;
				res_full_q <= 1'b1;
				res_cnt_q  <= '0;
			end
		end
	end

	// Output register: hold the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (counts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kmer_q <= canon_q;
			out_slot_q <= res_full_q ? '0 : ckc_pkg::SLOT_W'(idx_q);
			out_cnt_q  <= res_cnt_q;
			out_new_q  <= res_new_q;
			out_full_q <= res_full_q;
		end
	end

	assign counts.valid          = out_valid_q;
	assign counts.canonical_kmer = out_kmer_q;
	assign counts.slot           = out_slot_q;
	assign counts.occurrences    = out_cnt_q;
	assign counts.newly_inserted = out_new_q;
	assign counts.table_full     = out_full_q;
endmodule
